[sv/bgdc_pkg.sv]
package bgdc_pkg;

  typedef logic [15:0] tick_t;
  typedef logic [3:0]  digit_t;
  typedef logic [6:0]  seg_t;
  typedef logic [2:0]  event_t;
  typedef logic [3:0]  reg_index_t;

  // Gesture event codes
  localparam event_t EV_NONE   = 3'd0;
  localparam event_t EV_SINGLE = 3'd1;
  localparam event_t EV_DOUBLE = 3'd2;
  localparam event_t EV_LONG   = 3'd3;
  localparam event_t EV_REPEAT = 3'd4;

  // Configuration register indexes
  localparam reg_index_t REG_DEBOUNCE     = 4'd0;
  localparam reg_index_t REG_DOUBLE_CLICK = 4'd1;
  localparam reg_index_t REG_LONG_PRESS   = 4'd2;
  localparam reg_index_t REG_REPEAT       = 4'd3;

  localparam tick_t DEBOUNCE_RESET     = 16'd25;
  localparam tick_t DOUBLE_CLICK_RESET = 16'd350;
  localparam tick_t LONG_PRESS_RESET   = 16'd800;
  localparam tick_t REPEAT_RESET       = 16'd500;
  localparam tick_t TICK_MAX           = 16'hFFFF;

  localparam digit_t DIGIT_LAST = 4'd9;

  typedef struct packed {
    tick_t debounce_ticks;
    tick_t double_click_ticks;
    tick_t long_press_ticks;
    tick_t repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic button_level;
  } in_word_t;

  typedef struct packed {
    digit_t digit;
    seg_t   segments;
    event_t gesture_event;
  } out_word_t;

  typedef struct packed {
    digit_t digit;
    event_t gesture_event;
  } gesture_result_t;

  function automatic tick_t sat_inc(tick_t v);
    return (v == TICK_MAX) ? v : v + 16'd1;
  endfunction

  function automatic digit_t digit_up(digit_t d);
    return (d >= DIGIT_LAST) ? 4'd0 : d + 4'd1;
  endfunction

  function automatic digit_t digit_down(digit_t d);
    return (d == 4'd0) ? DIGIT_LAST : d - 4'd1;
  endfunction

  // Common-cathode pattern, bit 0 is segment a
  function automatic seg_t seg_pattern(digit_t d);
    seg_t s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

endpackage

[sv/bgdc_if.sv]
interface bgdc_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/bgdc_cfg_regs.sv]
module bgdc_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  bgdc_pkg::reg_index_t  cfg_index,
  input  bgdc_pkg::tick_t       cfg_wdata,
  output bgdc_pkg::cfg_t        cfg
);
  import bgdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.double_click_ticks <= DOUBLE_CLICK_RESET;
      cfg.long_press_ticks   <= LONG_PRESS_RESET;
      cfg.repeat_ticks       <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_wdata;
        REG_DOUBLE_CLICK: cfg.double_click_ticks <= cfg_wdata;
        REG_LONG_PRESS:   cfg.long_press_ticks   <= cfg_wdata;
        REG_REPEAT:       cfg.repeat_ticks       <= cfg_wdata;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

[sv/bgdc_gesture.sv]
module bgdc_gesture (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     button_level,
  input  bgdc_pkg::cfg_t           cfg,
  output bgdc_pkg::gesture_result_t res
);
  import bgdc_pkg::*;

  digit_t count_value,    count_value_next;
  logic   filtered_level, filtered_level_next;
  logic   previous_raw;
  tick_t  stable_ticks,   stable_ticks_next;
  logic   held_flag,      held_flag_next;
  logic   long_active,    long_active_next;
  logic   click_waiting,  click_waiting_next;
  tick_t  since_press,    since_press_next;
  tick_t  since_release,  since_release_next;
  tick_t  since_repeat,   since_repeat_next;
  event_t ev;

  always_comb begin
    ev                  = EV_NONE;
    count_value_next    = count_value;
    filtered_level_next = filtered_level;
    held_flag_next      = held_flag;
    long_active_next    = long_active;
    click_waiting_next  = click_waiting;
    since_press_next    = sat_inc(since_press);
    since_release_next  = sat_inc(since_release);
    since_repeat_next   = sat_inc(since_repeat);
    stable_ticks_next   = (button_level != previous_raw) ? '0 : sat_inc(stable_ticks);

    // debounced edge
    if (stable_ticks_next > cfg.debounce_ticks && button_level != filtered_level) begin
      filtered_level_next = button_level;
      if (!button_level) begin
        held_flag_next   = 1'b1;
        since_press_next = '0;
      end else begin
        held_flag_next     = 1'b0;
        since_release_next = '0;
        if (long_active) begin
          long_active_next = 1'b0;
        end else if (click_waiting) begin
          click_waiting_next = 1'b0;
          count_value_next   = digit_down(count_value);
          ev                 = EV_DOUBLE;
        end else begin
          click_waiting_next = 1'b1;
        end
      end
    end

    // gesture timers
    if (held_flag_next) begin
      if (!long_active_next && since_press_next >= cfg.long_press_ticks) begin
        long_active_next   = 1'b1;
        click_waiting_next = 1'b0;
        count_value_next   = digit_up(count_value_next);
        since_repeat_next  = '0;
        ev                 = EV_LONG;
      end else if (long_active_next && since_repeat_next >= cfg.repeat_ticks) begin
        count_value_next  = digit_up(count_value_next);
        since_repeat_next = '0;
        ev                = EV_REPEAT;
      end
    end else if (click_waiting_next && since_release_next >= cfg.double_click_ticks) begin
      click_waiting_next = 1'b0;
      count_value_next   = digit_up(count_value_next);
      ev                 = EV_SINGLE;
    end
  end

  assign res.digit         = count_value_next;
  assign res.gesture_event = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      filtered_level <= 1'b1;
      previous_raw   <= 1'b1;
      stable_ticks   <= '0;
      held_flag      <= 1'b0;
      long_active    <= 1'b0;
      click_waiting  <= 1'b0;
      since_press    <= '0;
      since_release  <= '0;
      since_repeat   <= '0;
    end else if (step) begin
      count_value    <= count_value_next;
      filtered_level <= filtered_level_next;
      previous_raw   <= button_level;
      stable_ticks   <= stable_ticks_next;
      held_flag      <= held_flag_next;
      long_active    <= long_active_next;
      click_waiting  <= click_waiting_next;
      since_press    <= since_press_next;
      since_release  <= since_release_next;
      since_repeat   <= since_repeat_next;
    end
  end

endmodule

[sv/button_gesture_digit_counter_core.sv]
// Channel  | Dir | Payload word                            | Handshake
// ---------+-----+-----------------------------------------+-------------
// in_ch    | in  | button_level (1b, 0 = pressed)          | valid/ready
// out_ch   | out | digit (4b), segments (7b), event (3b)   | valid/ready
// cfg      | in  | cfg_we, cfg_index (4b), cfg_wdata (16b) | write enable
//
// One word per cycle sustained while out_ch is ready; each accepted word passes
// through the input register, then the gesture update into the result register.
// The gesture state advances only when a word moves from the input register
// into the result register, so stalls on out_ch never skip or repeat a tick.
// Synchronous active-high reset clears valids, gesture state and configuration registers.
// in_ch stays ready while a result waits, as long as the input register is free.
module button_gesture_digit_counter_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  bgdc_pkg::reg_index_t cfg_index,
  input  bgdc_pkg::tick_t      cfg_wdata,
  bgdc_if.sink                 in_ch,
  bgdc_if.source               out_ch
);
  import bgdc_pkg::*;

  cfg_t            cfg;
  gesture_result_t res;

  logic      s1_valid;
  logic      s1_level;
  logic      out_valid;
  out_word_t out_word;
  logic      advance;
  logic      step;

  // Move the held word forward when the result register is free or drains.
  assign advance     = !out_valid || out_ch.ready;
  assign step        = s1_valid && advance;
  assign in_ch.ready = !s1_valid || advance;

  bgdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bgdc_gesture u_gesture (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .button_level (s1_level),
    .cfg          (cfg),
    .res          (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_level <= in_ch.payload.button_level;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word.digit         <= res.digit;
      out_word.segments      <= seg_pattern(res.digit);
      out_word.gesture_event <= res.gesture_event;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_word;

endmodule

[sv/bgdc_checker.sv]
module bgdc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input bgdc_pkg::out_word_t out_word
);
  import bgdc_pkg::*;

  digit_t last_digit;
  logic   out_take;

  assign out_take = out_valid && out_ready;

  // Track the digit of the last delivered word; the counter starts at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_digit <= '0;
    end else if (out_take) begin
      last_digit <= out_word.digit;
    end
  end

  a_seg_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.digit <= DIGIT_LAST &&
                   out_word.segments == seg_pattern(out_word.digit)))
    else $error("segments do not match digit");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.gesture_event <= EV_REPEAT)
    else $error("gesture event out of range");

  a_no_event_hold: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_word.gesture_event == EV_NONE) |-> out_word.digit == last_digit)
    else $error("digit changed without an event");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (out_take && (out_word.gesture_event == EV_SINGLE ||
                  out_word.gesture_event == EV_LONG ||
                  out_word.gesture_event == EV_REPEAT))
    |-> out_word.digit == digit_up(last_digit))
    else $error("increment event without digit increment");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_word.gesture_event == EV_DOUBLE)
    |-> out_word.digit == digit_down(last_digit))
    else $error("double click without digit decrement");

endmodule

bind button_gesture_digit_counter_core bgdc_checker u_bgdc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.payload)
);
